// ----- design/ultrasonic_echo_ranger_macros.svh -----
// Assertion macros for the ultrasonic echo ranger.
// Included by the top level; expects clk and rst in scope at the point of use.
`ifndef ULTRASONIC_ECHO_RANGER_MACROS_SVH
`define ULTRASONIC_ECHO_RANGER_MACROS_SVH

`ifndef SYNTH

// Consequent must hold in the same cycle as the antecedent.
`define UER_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ultrasonic_echo_ranger: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define UER_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ultrasonic_echo_ranger: next-cycle check failed");

`else

`define UER_ASSERT_NOW(label, ante, cons)
`define UER_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- design/uer_pkg.sv -----
// Shared types, codes and widths for the ultrasonic echo ranger.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package uer_pkg;

  // Widths of the idle counter and of the edge timestamps.
  localparam int TICK_COUNT_WIDTH = 16;
  localparam int STAMP_WIDTH      = 64;

  // Port widths fixed by the interface.
  localparam int CFG_WIDTH   = 16;
  localparam int TIME_WIDTH  = 64;
  localparam int PADDR_WIDTH = 3;
  localparam int PDATA_WIDTH = 32;

  // Common width for comparing the idle count against a limit register.
  localparam int CMP_WIDTH = (TICK_COUNT_WIDTH > CFG_WIDTH) ? TICK_COUNT_WIDTH : CFG_WIDTH;

  // Item kinds.
  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_EDGE = 1'b1;

  // Edge kinds; any other code is an unknown edge.
  localparam logic [1:0] EDGE_RISING  = 2'd0;
  localparam logic [1:0] EDGE_FALLING = 2'd1;

  // Register select, taken from paddr[2].
  localparam logic REG_ACTIVE   = 1'b0;
  localparam logic REG_INACTIVE = 1'b1;

  // Reset values of the limit registers.
  localparam logic [CFG_WIDTH-1:0] ACTIVE_RESET   = CFG_WIDTH'(10);
  localparam logic [CFG_WIDTH-1:0] INACTIVE_RESET = CFG_WIDTH'(60);

  typedef enum logic [2:0] {
    ST_NONE    = 3'd0,
    ST_WIDTH   = 3'd1,
    ST_ZERO    = 3'd2,
    ST_UNKNOWN = 3'd3,
    ST_TOGGLE  = 3'd4
  } status_t;

  // One input beat.
  typedef struct packed {
    logic                  mode;
    logic [1:0]            edge_kind;
    logic [TIME_WIDTH-1:0] edge_time;
  } item_t;

  // One result beat.
  typedef struct packed {
    logic                  trigger_level;
    status_t               status;
    logic [TIME_WIDTH-1:0] pulse_width;
  } result_t;

endpackage

// ----- design/uer_in_reg.sv -----
// Input register stage of the ultrasonic echo ranger.
// Depends on uer_pkg for the item type.
`timescale 1ns / 1ps

module uer_in_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  uer_pkg::item_t in_item,
  input  logic          advance,
  output logic          held_valid,
  output uer_pkg::item_t held_item
);
  import uer_pkg::*;

  // The stage takes a new beat when empty or when its beat moves on.
  assign in_ready = !held_valid || advance;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  // Payload, no reset needed.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_item <= in_item;
    end
  end

endmodule

// ----- design/uer_core.sv -----
// Trigger timing and echo width logic with its state registers.
// Depends on uer_pkg for types, codes and widths.
`timescale 1ns / 1ps

module uer_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              fire,
  input  uer_pkg::item_t                    item,
  input  logic [uer_pkg::CFG_WIDTH-1:0]     active_ticks,
  input  logic [uer_pkg::CFG_WIDTH-1:0]     inactive_ticks,
  output uer_pkg::result_t                  res,
  output logic                              trigger_now
);
  import uer_pkg::*;

  logic                        trigger_state, trigger_state_next;
  logic [TICK_COUNT_WIDTH-1:0] idle_count, idle_count_next;
  logic [STAMP_WIDTH-1:0]      rise_stamp, rise_stamp_next;
  logic [1:0]                  previous_edge, previous_edge_next;

  logic [TICK_COUNT_WIDTH-1:0] count_inc;
  logic [CFG_WIDTH-1:0]        limit;
  logic [STAMP_WIDTH-1:0]      stamp;
  logic [STAMP_WIDTH-1:0]      diff;
  logic                        later;

  assign trigger_now = trigger_state;

  // Saturating tick count, the limit for the present level, and the width.
  assign count_inc = (idle_count != '1) ? idle_count + 1'b1 : idle_count;
  assign limit     = trigger_state ? active_ticks : inactive_ticks;
  assign stamp     = item.edge_time[STAMP_WIDTH-1:0];
  assign later     = stamp > rise_stamp;
  assign diff      = stamp - rise_stamp;

  // Next state and result for the held beat.
  always_comb begin
    trigger_state_next = trigger_state;
    idle_count_next    = idle_count;
    rise_stamp_next    = rise_stamp;
    previous_edge_next = previous_edge;
    res.trigger_level  = trigger_state;
    res.status         = ST_NONE;
    res.pulse_width    = '0;
    if (item.mode == MODE_TICK) begin
      idle_count_next = count_inc;
      if (CMP_WIDTH'(count_inc) >= CMP_WIDTH'(limit)) begin
        trigger_state_next = !trigger_state;
        idle_count_next    = '0;
        res.status         = ST_TOGGLE;
      end
    end else begin
      idle_count_next    = '0;
      previous_edge_next = item.edge_kind;
      case (item.edge_kind)
        EDGE_RISING: begin
          rise_stamp_next = stamp;
        end
        EDGE_FALLING: begin
          if (previous_edge == EDGE_RISING) begin
            if (later) begin
              res.status      = ST_WIDTH;
              res.pulse_width = TIME_WIDTH'(diff);
            end else begin
              res.status = ST_ZERO;
            end
          end
        end
        default: begin
          res.status = ST_UNKNOWN;
        end
      endcase
    end
    res.trigger_level = trigger_state_next;
  end

  // State registers advance once per beat that moves to the output.
  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_state <= 1'b1;
      idle_count    <= '0;
      rise_stamp    <= '0;
      previous_edge <= EDGE_FALLING;
    end else if (fire) begin
      trigger_state <= trigger_state_next;
      idle_count    <= idle_count_next;
      rise_stamp    <= rise_stamp_next;
      previous_edge <= previous_edge_next;
    end
  end

endmodule

// ----- design/uer_out_reg.sv -----
// Result register of the ultrasonic echo ranger.
// Depends on uer_pkg for the result type.
`timescale 1ns / 1ps

module uer_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load_valid,
  output logic             can_load,
  input  uer_pkg::result_t res_next,
  output logic             out_valid,
  input  logic             out_ready,
  output uer_pkg::result_t res
);
  import uer_pkg::*;

  // A new result may enter when the register is empty or its beat leaves.
  assign can_load = !out_valid || out_ready;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= load_valid;
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (load_valid && can_load) begin
      res <= res_next;
    end
  end

endmodule

// ----- design/ultrasonic_echo_ranger.sv -----
// Ultrasonic echo ranger: drives the trigger and times echo pulses, one result per beat.
// It accepts one item every clock cycle while the receiver keeps taking results, and returns each
// result through the input register followed by the result register; the only wide path is
// one 64-bit compare and subtract on the echo timestamp. Ready falls only while the
// result register is full and not taken. The limit registers sit on an APB port at
// byte 0 (active_ticks) and byte 4 (inactive_ticks) and should be written only when idle.
// Depends on uer_pkg, uer_in_reg, uer_core, uer_out_reg and the assertion macro header.
`timescale 1ns / 1ps
`include "ultrasonic_echo_ranger_macros.svh"

module ultrasonic_echo_ranger (
  input  logic                                clk,
  input  logic                                rst,
  // Item channel.
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                mode,
  input  logic [1:0]                          edge_kind,
  input  logic [uer_pkg::TIME_WIDTH-1:0]      edge_time,
  // Result channel.
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                trigger_level,
  output logic [2:0]                          status,
  output logic [uer_pkg::TIME_WIDTH-1:0]      pulse_width,
  // Configuration port.
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [uer_pkg::PADDR_WIDTH-1:0]     paddr,
  input  logic [uer_pkg::PDATA_WIDTH-1:0]     pwdata,
  output logic [uer_pkg::PDATA_WIDTH-1:0]     prdata,
  output logic                                pready
);
  import uer_pkg::*;

  item_t                in_item;
  item_t                held_item;
  logic                 held_valid;
  logic                 can_load;
  logic                 fire;
  result_t              res_next;
  result_t              res;
  logic                 trigger_now;
  logic [CFG_WIDTH-1:0] active_ticks;
  logic [CFG_WIDTH-1:0] inactive_ticks;
  logic                 cfg_write;

  // Limit registers behind the APB port.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == REG_INACTIVE) ? PDATA_WIDTH'(inactive_ticks)
                                                : PDATA_WIDTH'(active_ticks);

  always_ff @(posedge clk) begin
    if (rst) begin
      active_ticks   <= ACTIVE_RESET;
      inactive_ticks <= INACTIVE_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == REG_ACTIVE) begin
        active_ticks <= pwdata[CFG_WIDTH-1:0];
      end else begin
        inactive_ticks <= pwdata[CFG_WIDTH-1:0];
      end
    end
  end

  // Pack the input beat.
  assign in_item.mode      = mode;
  assign in_item.edge_kind = edge_kind;
  assign in_item.edge_time = edge_time;

  // The held beat is processed when the result register can take it.
  assign fire = held_valid && can_load;

  uer_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .advance    (fire),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  uer_core u_core (
    .clk            (clk),
    .rst            (rst),
    .fire           (fire),
    .item           (held_item),
    .active_ticks   (active_ticks),
    .inactive_ticks (inactive_ticks),
    .res            (res_next),
    .trigger_now    (trigger_now)
  );

  uer_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load_valid (held_valid),
    .can_load   (can_load),
    .res_next   (res_next),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .res        (res)
  );

  // Unpack the result beat.
  assign trigger_level = res.trigger_level;
  assign status        = res.status;
  assign pulse_width   = res.pulse_width;

  // A reported width is never zero.
  `UER_ASSERT_NOW(a_width_nonzero, out_valid && res.status == ST_WIDTH, pulse_width != '0)

  // Every other status carries a zero width.
  `UER_ASSERT_NOW(a_width_only_reported, out_valid && res.status != ST_WIDTH, pulse_width == '0)

  // The trigger level moves only with a toggle result.
  `UER_ASSERT_NOW(a_level_follows_toggle, fire && res_next.status != ST_TOGGLE, res_next.trigger_level == trigger_now)

  // After a processed beat the trigger state matches the level just reported.
  `UER_ASSERT_NEXT(a_state_matches_result, fire, trigger_now == res.trigger_level)

endmodule

// ----- test/ultrasonic_echo_ranger_tb.sv -----
// Self-checking testbench for the ultrasonic echo ranger: directed edge cases, back-pressure
// and random ranging traffic, each result checked against a behavioral predictor.
// Depends on uer_pkg and the ultrasonic_echo_ranger top level.
`timescale 1ns / 1ps

module ultrasonic_echo_ranger_tb;
  import uer_pkg::*;

  // Register addresses on the configuration port.
  localparam logic [PADDR_WIDTH-1:0] ADDR_ACTIVE   = PADDR_WIDTH'(0);
  localparam logic [PADDR_WIDTH-1:0] ADDR_INACTIVE = PADDR_WIDTH'(4);

  // Edge codes that the block treats as unknown.
  localparam logic [1:0] EDGE_ODD_LOW  = 2'd2;
  localparam logic [1:0] EDGE_ODD_HIGH = 2'd3;

  // Receiver stall styles.
  localparam int RX_FREE    = 0;
  localparam int RX_SPARSE  = 1;
  localparam int RX_HEAVY   = 2;
  localparam int RX_CADENCE = 3;

  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 3000;
  localparam int REPORT_LIMIT = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   in_valid  = 1'b0;
  logic                   in_ready;
  logic                   mode      = MODE_TICK;
  logic [1:0]             edge_kind = EDGE_RISING;
  logic [TIME_WIDTH-1:0]  edge_time = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   trigger_level;
  logic [2:0]             status;
  logic [TIME_WIDTH-1:0]  pulse_width;
  logic                   psel      = 1'b0;
  logic                   penable   = 1'b0;
  logic                   pwrite    = 1'b0;
  logic [PADDR_WIDTH-1:0] paddr     = '0;
  logic [PDATA_WIDTH-1:0] pwdata    = '0;
  logic [PDATA_WIDTH-1:0] prdata;
  logic                   pready;

  ultrasonic_echo_ranger DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .mode          (mode),
    .edge_kind     (edge_kind),
    .edge_time     (edge_time),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .trigger_level (trigger_level),
    .status        (status),
    .pulse_width   (pulse_width),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #1 clk = ~clk;

  // Predicted ranger state and limit registers, starting at their reset values.
  logic                        trigger_now    = 1'b1;
  logic [TICK_COUNT_WIDTH-1:0] idle_ticks     = '0;
  logic [STAMP_WIDTH-1:0]      echo_rise_ns   = '0;
  logic [1:0]                  last_edge_kind = EDGE_FALLING;
  logic [CFG_WIDTH-1:0]        limit_active   = ACTIVE_RESET;
  logic [CFG_WIDTH-1:0]        limit_inactive = INACTIVE_RESET;

  result_t pending_results[$];
  int      mismatch_count = 0;
  int      quiet_cycles   = 0;

  // Sender burst control.
  bit gaps_on    = 1'b0;
  int burst_left = 0;

  // Long receiver hold-offs asked for by the tests.
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int rx_style  = RX_FREE;
  int rx_span   = 0;
  int rx_cycle  = 0;

  function automatic void report_mismatch(string what);
    if (mismatch_count < REPORT_LIMIT) $display("MISMATCH: %s", what);
    mismatch_count++;
  endfunction

  // Works out the result of one item and advances the predicted state.
  function automatic result_t ranger_predict(logic m, logic [1:0] k, logic [TIME_WIDTH-1:0] t);
    result_t              r;
    logic [CFG_WIDTH-1:0] lim;
    r.trigger_level = 1'b0;
    r.status        = ST_NONE;
    r.pulse_width   = '0;
    if (m == MODE_TICK) begin
      lim = trigger_now ? limit_active : limit_inactive;
      if (idle_ticks != '1) idle_ticks++;
      if (CMP_WIDTH'(idle_ticks) >= CMP_WIDTH'(lim)) begin
        trigger_now = ~trigger_now;
        idle_ticks  = '0;
        r.status    = ST_TOGGLE;
      end
    end else begin
      idle_ticks = '0;
      if (k == EDGE_RISING) begin
        echo_rise_ns = t[STAMP_WIDTH-1:0];
      end else if (k == EDGE_FALLING) begin
        // Only a falling edge right after a rising one measures a pulse.
        if (last_edge_kind == EDGE_RISING) begin
          if (t[STAMP_WIDTH-1:0] > echo_rise_ns) begin
            r.pulse_width = TIME_WIDTH'(t[STAMP_WIDTH-1:0] - echo_rise_ns);
            r.status      = ST_WIDTH;
          end else begin
            r.status = ST_ZERO;
          end
        end
      end else begin
        r.status = ST_UNKNOWN;
      end
      last_edge_kind = k;
    end
    r.trigger_level = trigger_now;
    return r;
  endfunction

  // Predict every accepted item and check every accepted result against the oldest prediction.
  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if (in_valid && in_ready) pending_results.push_back(ranger_predict(mode, edge_kind, edge_time));
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result beat with none pending: level %0b status %0d width %0h",
                                    trigger_level, status, pulse_width));
        end else begin
          want = pending_results.pop_front();
          if (trigger_level !== want.trigger_level || status !== want.status ||
              pulse_width !== want.pulse_width)
            report_mismatch($sformatf(
              "level %0b/%0b status %0d/%0d width %0h/%0h (expected/actual)",
              want.trigger_level, trigger_level, want.status, status,
              want.pulse_width, pulse_width));
        end
      end
    end
  end

  // The run ends if neither channel moves a beat for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("ultrasonic_echo_ranger test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: a long hold-off when asked, else stretches of its own stall styles.
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (hold_seen != hold_asks) begin
      hold_seen <= hold_asks;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      if (rx_span == 0) begin
        rx_style <= $urandom_range(RX_FREE, RX_CADENCE);
        rx_span  <= $urandom_range(16, 200);
      end else begin
        rx_span <= rx_span - 1;
      end
      case (rx_style)
        RX_FREE:    out_ready <= 1'b1;
        RX_SPARSE:  out_ready <= ($urandom_range(0, 3) != 0);
        RX_HEAVY:   out_ready <= ($urandom_range(0, 2) == 0);
        default:    out_ready <= ((rx_cycle % 7) < 4);
      endcase
    end
  end

  // Drops valid for a number of cycles.
  task automatic pause(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Offers one item and holds it until the block takes the beat.
  task automatic send_item(input logic m, input logic [1:0] k, input logic [TIME_WIDTH-1:0] t);
    in_valid  <= 1'b1;
    mode      <= m;
    edge_kind <= k;
    edge_time <= t;
    do @(posedge clk); while (!in_ready);
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        pause($urandom_range(1, 8));
      end else begin
        burst_left--;
      end
    end
  endtask

  // A tick carries random junk in the fields that it ignores.
  task automatic send_tick();
    send_item(MODE_TICK, 2'($urandom_range(0, 3)), {$urandom, $urandom});
  endtask

  // Stops sending and waits until every predicted result has come back.
  task automatic wait_results_done();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // The port returns to idle after each transfer.
  task automatic reg_write(input logic [PADDR_WIDTH-1:0] addr, input logic [CFG_WIDTH-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= PDATA_WIDTH'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_ACTIVE) limit_active = value;
    else limit_inactive = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Reads a register back; prdata is sampled mid-cycle during the access phase.
  task automatic reg_check(input logic [PADDR_WIDTH-1:0] addr, input logic [CFG_WIDTH-1:0] want);
    logic [PDATA_WIDTH-1:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      got = prdata;
      @(posedge clk);
    end while (!pready);
    if (got[CFG_WIDTH-1:0] !== want)
      report_mismatch($sformatf("register at %0d read %0h, expected %0h", addr, got, want));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_limits(input logic [CFG_WIDTH-1:0] act, input logic [CFG_WIDTH-1:0] inact);
    wait_results_done();
    reg_write(ADDR_ACTIVE, act);
    reg_write(ADDR_INACTIVE, inact);
    reg_check(ADDR_ACTIVE, act);
    reg_check(ADDR_INACTIVE, inact);
  endtask

  // Echo timestamps: small, mid-range, near the top, or fully random.
  function automatic logic [TIME_WIDTH-1:0] rand_stamp();
    case ($urandom_range(0, 3))
      0:       return {$urandom, $urandom};
      1:       return TIME_WIDTH'($urandom_range(0, 1000));
      2:       return {32'hFFFF_FFFF, $urandom};
      default: return {24'd0, 8'($urandom_range(0, 255)), $urandom};
    endcase
  endfunction

  // Gap from rise to fall: mostly a plausible echo, sometimes zero, negative or huge.
  function automatic logic [TIME_WIDTH-1:0] rand_delta();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return TIME_WIDTH'(0) - TIME_WIDTH'($urandom_range(1, 1000));
      2:       return {$urandom, $urandom};
      default: return TIME_WIDTH'($urandom_range(1, 2000000));
    endcase
  endfunction

  // Random ranging traffic: mostly trigger cycles with an echo pulse, plus noise and
  // broken edge sequences.
  task automatic run_ranging(input int count);
    int                    sent;
    int                    lim;
    int                    k;
    logic [TIME_WIDTH-1:0] rise_t;
    sent = 0;
    while (sent < count) begin
      lim = trigger_now ? limit_active : limit_inactive;
      if (lim > 40) lim = 40;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          k = $urandom_range(0, lim + 1);
          repeat (k) send_tick();
          rise_t = rand_stamp();
          send_item(MODE_EDGE, EDGE_RISING, rise_t);
          // Ticks inside the pulse do not disturb the measurement.
          repeat ($urandom_range(0, 2)) begin
            send_tick();
            sent++;
          end
          send_item(MODE_EDGE, EDGE_FALLING, rise_t + rand_delta());
          sent += k + 2;
        end
        6, 7: begin
          send_item(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), rand_stamp());
          sent++;
        end
        8: begin
          case ($urandom_range(0, 2))
            0: send_item(MODE_EDGE, EDGE_FALLING, rand_stamp());
            1: send_item(MODE_EDGE, EDGE_RISING, rand_stamp());
            default: send_item(MODE_EDGE, 2'($urandom_range(EDGE_ODD_LOW, EDGE_ODD_HIGH)),
                               rand_stamp());
          endcase
          send_item(MODE_EDGE, EDGE_RISING, rand_stamp());
          send_item(MODE_EDGE, EDGE_FALLING, rand_stamp());
          sent += 3;
        end
        default: begin
          k = $urandom_range(1, lim + 3);
          repeat (k) send_tick();
          sent += k;
        end
      endcase
    end
  endtask

  // Reset values of the registers, and a full active period at the default limit.
  task automatic test_register_defaults();
    reg_check(ADDR_ACTIVE, ACTIVE_RESET);
    reg_check(ADDR_INACTIVE, INACTIVE_RESET);
    repeat (10) send_tick();
  endtask

  // Limit of zero, timestamp extremes, zero and negative widths, lone falling edges,
  // unknown edges, repeated rising edges and idle count clearing.
  task automatic test_edge_cases();
    gaps_on = 1'b0;
    set_limits(CFG_WIDTH'(2), CFG_WIDTH'(0));
    send_item(MODE_TICK, EDGE_RISING, '0);
    send_tick();
    send_item(MODE_EDGE, EDGE_RISING, '0);
    send_tick();
    send_tick();
    send_item(MODE_EDGE, EDGE_FALLING, '0);
    send_item(MODE_EDGE, EDGE_RISING, '1);
    send_item(MODE_EDGE, EDGE_FALLING, '1);
    send_item(MODE_EDGE, EDGE_RISING, '1);
    send_item(MODE_EDGE, EDGE_FALLING, '0);
    send_item(MODE_EDGE, EDGE_RISING, '0);
    send_item(MODE_EDGE, EDGE_FALLING, '1);
    send_item(MODE_EDGE, EDGE_FALLING, TIME_WIDTH'(5));
    send_item(MODE_EDGE, EDGE_ODD_LOW, TIME_WIDTH'(7));
    send_item(MODE_EDGE, EDGE_ODD_HIGH, '1);
    send_item(MODE_EDGE, EDGE_RISING, TIME_WIDTH'(100));
    send_item(MODE_EDGE, EDGE_ODD_LOW, TIME_WIDTH'(150));
    send_item(MODE_EDGE, EDGE_FALLING, TIME_WIDTH'(200));
    send_item(MODE_EDGE, EDGE_RISING, TIME_WIDTH'(100));
    send_item(MODE_EDGE, EDGE_RISING, TIME_WIDTH'(300));
    send_item(MODE_EDGE, EDGE_FALLING, TIME_WIDTH'(350));
    send_item(MODE_TICK, EDGE_ODD_HIGH, '1);
    set_limits(CFG_WIDTH'(1), CFG_WIDTH'(0));
    send_tick();
    send_tick();
    send_tick();
  endtask

  // The receiver holds off while items keep coming, so the block must stall its input.
  task automatic test_backpressure();
    set_limits(CFG_WIDTH'(3), CFG_WIDTH'(5));
    gaps_on   = 1'b0;
    hold_asks = hold_asks + 1;
    run_ranging(80);
    wait_results_done();
  endtask

  // Random ranging under extreme and random limit settings.
  task automatic test_random_ranging();
    set_limits(CFG_WIDTH'(1), CFG_WIDTH'(1));
    gaps_on = 1'b1;
    run_ranging(150);
    set_limits('1, '1);
    run_ranging(150);
    set_limits(CFG_WIDTH'(1), '1);
    gaps_on = 1'b0;
    run_ranging(150);
    set_limits('1, CFG_WIDTH'(1));
    gaps_on = 1'b1;
    run_ranging(150);
    repeat (5) begin
      set_limits(CFG_WIDTH'($urandom_range(1, 16)), CFG_WIDTH'($urandom_range(1, 40)));
      gaps_on = ($urandom_range(0, 3) != 0);
      run_ranging(200);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_register_defaults();
    test_edge_cases();
    test_backpressure();
    test_random_ranging();
    wait_results_done();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ultrasonic_echo_ranger test passed");
    end else begin
      $display("ultrasonic_echo_ranger test failed");
    end
    $finish;
  end

endmodule
